### rtl/hdwc_pkg.sv
// Shared types and constants for the heater duty-window controller.
// No dependencies; the core and the checker refer to it by scoped names, the sim files import it.
`default_nettype none

package hdwc_pkg;

	localparam int TEMP_W     = 12;
	localparam int DUTY_W     = 7;
	localparam int CFG_DATA_W = 12;
	localparam int CFG_IDX_W  = 1;

	// input word kinds
	localparam logic KIND_TICK   = 1'b0;
	localparam logic KIND_SAMPLE = 1'b1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_TEMP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT  = 1'b1;

	localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;

	typedef logic signed [TEMP_W-1:0] temp_t;
	typedef logic [DUTY_W-1:0] duty_t;

	typedef struct packed {
		logic  kind;
		temp_t temperature;
		logic  level_covered;
	} in_word_t;

	typedef struct packed {
		logic heater_on;
		logic target_reached;
		logic heating_wanted;
	} out_word_t;

endpackage

`default_nettype wire

### rtl/hdwc_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
// Depends on nothing; the word type is supplied at instantiation.
`default_nettype none

interface hdwc_stream_if #(
	parameter type word_t = logic
) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/heater_duty_window_control_core.sv
// Top level of the heater duty-window controller.
// Uses hdwc_pkg and the hdwc_stream_if channel interface.
//
// Usage:
//   item   - input words (kind, temperature, level_covered): a tick of the
//            duty window (kind 0) or a new temperature sample (kind 1).
//   result - one output word per input word: heater_on, target_reached,
//            heating_wanted, in input order.
//   cfg_*  - write-only register port: index 0 target_temp (signed, 1/16 C,
//            clears the reached flag), index 1 duty_limit (7 bits).
// An accepted word enters the input register; the compare logic (five parallel
// ring comparators, phase/duty compare) then settles into the result register.
// Throughput is one word per cycle while the receiver keeps result.ready high.
// Reset (arst_n low) clears the window phase, latest temperature, ring fill,
// reached flag and relay; target_temp goes to 0 and duty_limit to 50.
// When the receiver stalls, the result is held and the input register keeps
// one more word; item.ready drops only when both are occupied.
`default_nettype none

module heater_duty_window_control_core #(
	parameter int RING_DEPTH   = 5,
	parameter int WINDOW_TICKS = 100
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	hdwc_stream_if.sink                              item,
	hdwc_stream_if.source                            result,
	input  wire logic                                cfg_we,
	input  wire logic [hdwc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [hdwc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int PHASE_W = (WINDOW_TICKS > 2) ? $clog2(WINDOW_TICKS) : 1;
	localparam int CMP_W   = (PHASE_W > hdwc_pkg::DUTY_W) ? PHASE_W : hdwc_pkg::DUTY_W;
	localparam int POS_W   = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W  = $clog2(RING_DEPTH + 1);

	localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(WINDOW_TICKS - 1);
	localparam logic [POS_W-1:0]   POS_LAST   = POS_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0]  FILL_FULL  = FILL_W'(RING_DEPTH);

	// configuration
	hdwc_pkg::temp_t target_q;
	hdwc_pkg::duty_t duty_q;

	// state
	logic [PHASE_W-1:0] phase_q;
	hdwc_pkg::temp_t    latest_q;
	hdwc_pkg::temp_t    ring_q [RING_DEPTH];
	logic [POS_W-1:0]   pos_q;
	logic [FILL_W-1:0]  fill_q;
	logic               reached_q;
	logic               relay_q;

	// pipeline
	logic                 s1_v_q;
	hdwc_pkg::in_word_t   s1_q;
	logic                 out_v_q;
	hdwc_pkg::out_word_t  out_q;

	logic                 adv;
	logic                 process;
	logic                 is_sample;
	logic                 heat_cond;
	logic                 ring_all_ok;
	logic                 reached_eval;
	logic [RING_DEPTH-1:0] entry_ok;
	hdwc_pkg::temp_t      latest_nxt;
	hdwc_pkg::out_word_t  out_nxt;
	logic                 target_wr;

	assign adv        = !out_v_q || result.ready;
	assign item.ready = !s1_v_q || adv;
	assign process    = s1_v_q && adv;
	assign is_sample  = (s1_q.kind == hdwc_pkg::KIND_SAMPLE);
	assign target_wr  = cfg_we && (cfg_index == hdwc_pkg::REG_TARGET_TEMP);

	assign result.valid = out_v_q;
	assign result.data  = out_q;

	always_comb begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			entry_ok[i] = (ring_q[i] >= target_q);
		end
	end

	assign ring_all_ok  = (fill_q == FILL_FULL) && (&entry_ok);
	assign reached_eval = reached_q || ring_all_ok;

	assign heat_cond = (latest_q < target_q)
		&& (CMP_W'(phase_q) <= CMP_W'(duty_q))
		&& s1_q.level_covered;

	assign latest_nxt = is_sample ? s1_q.temperature : latest_q;

	always_comb begin
		if (is_sample) begin
			out_nxt.heater_on      = relay_q;
			out_nxt.target_reached = reached_q;
		end else begin
			out_nxt.heater_on      = heat_cond;
			out_nxt.target_reached = heat_cond ? reached_q : reached_eval;
		end
		out_nxt.heating_wanted = (latest_nxt < target_q) && s1_q.level_covered;
	end

	// handshake and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (item.ready) begin
				s1_v_q <= item.valid;
			end
			if (adv) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			s1_q <= item.data;
		end
		if (process) begin
			out_q <= out_nxt;
		end
	end

	// configuration registers and the reached flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q  <= '0;
			duty_q    <= hdwc_pkg::DUTY_RESET;
			reached_q <= 1'b0;
		end else begin
			if (target_wr) begin
				target_q  <= cfg_data[hdwc_pkg::TEMP_W-1:0];
				reached_q <= 1'b0;
			end else if (process && !is_sample && !heat_cond) begin
				reached_q <= reached_eval;
			end
			if (cfg_we && (cfg_index == hdwc_pkg::REG_DUTY_LIMIT)) begin
				duty_q <= cfg_data[hdwc_pkg::DUTY_W-1:0];
			end
		end
	end

	// window, relay and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			latest_q <= '0;
			pos_q    <= '0;
			fill_q   <= '0;
			relay_q  <= 1'b0;
		end else if (process) begin
			if (is_sample) begin
				latest_q <= s1_q.temperature;
				phase_q  <= '0;
				pos_q    <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				if (fill_q != FILL_FULL) begin
					fill_q <= fill_q + 1'b1;
				end
			end else begin
				relay_q <= heat_cond;
				phase_q <= (phase_q == PHASE_LAST) ? '0 : phase_q + 1'b1;
			end
		end
	end

	// reading ring, no reset: entries are read only once all are written
	always_ff @(posedge clk) begin
		for (int i = 0; i < RING_DEPTH; i++) begin
			if (process && is_sample && (pos_q == POS_W'(i))) begin
				ring_q[i] <= s1_q.temperature;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/hdwc_checker.sv
// Port-level checks for the heater duty-window controller, bound to the top.
// Uses hdwc_pkg for the result word type.
`default_nettype none

module hdwc_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 item_valid,
	input wire logic                 item_ready,
	input wire logic                 result_valid,
	input wire logic                 result_ready,
	input wire hdwc_pkg::out_word_t  result_data
);

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result word changed or dropped while stalled");

	// a result rising from empty comes from an accepted word that passed the input register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(item_valid && item_ready, 2))
		else $error("result appeared without an accepted input word");

	// input back-pressure only when the output side is full and stalled
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid && !result_ready)
		else $error("input stalled while the output could advance");

	// nothing is presented right after reset is applied
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |=> !result_valid)
		else $error("result valid right after reset");

endmodule

bind heater_duty_window_control_core hdwc_checker u_hdwc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

`default_nettype wire

### sim/hdwc_result_check.sv
// Checker for the heater duty-window controller: watches the item, result and config ports,
// forecasts each result word with its own controller model and compares field by field.
// Depends on hdwc_pkg.
module hdwc_result_check #(
	parameter int RING_DEPTH   = 5,
	parameter int WINDOW_TICKS = 100
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	input  logic                              item_ready,
	input  hdwc_pkg::in_word_t                item_data,
	input  logic                              result_valid,
	input  logic                              result_ready,
	input  hdwc_pkg::out_word_t               result_data,
	input  logic                              cfg_we,
	input  logic [hdwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [hdwc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output int                                fail_count,
	output int                                words_due
);
	import hdwc_pkg::*;

	// controller copy
	temp_t target_temp;
	duty_t duty_limit;
	int    phase;
	temp_t latest_temp;
	temp_t readings[RING_DEPTH];
	int    wr_pos;
	int    fill;
	logic  reached;
	logic  relay;

	out_word_t forecast_q[$];
	out_word_t want;
	int        mismatches = 0;

	assign fail_count = mismatches;

	function automatic out_word_t step_controller(in_word_t w);
		out_word_t o;
		logic      all_hot;
		temp_t     t;
		t = $signed(w.temperature);
		if (w.kind == KIND_SAMPLE) begin
			latest_temp = t;
			readings[wr_pos] = t;
			wr_pos = (wr_pos + 1) % RING_DEPTH;
			if (fill < RING_DEPTH)
				fill++;
			phase = 0;
		end else begin
			if (latest_temp < target_temp && phase <= duty_limit && w.level_covered) begin
				relay = 1'b1;
			end else begin
				// sticky; only judged once the ring is full
				if (!reached && fill == RING_DEPTH) begin
					all_hot = 1'b1;
					for (int i = 0; i < RING_DEPTH; i++)
						if (readings[i] < target_temp)
							all_hot = 1'b0;
					reached = all_hot;
				end
				relay = 1'b0;
			end
			phase++;
			if (phase >= WINDOW_TICKS)
				phase = 0;
		end
		o.heater_on      = relay;
		o.target_reached = reached;
		o.heating_wanted = (latest_temp < target_temp) && w.level_covered;
		return o;
	endfunction

	task automatic note_mismatch(input out_word_t exp_w, input out_word_t got_w);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: result word mismatch: expected on=%0b reached=%0b wanted=%0b, got on=%0b reached=%0b wanted=%0b",
				$realtime, exp_w.heater_on, exp_w.target_reached, exp_w.heating_wanted,
				got_w.heater_on, got_w.target_reached, got_w.heating_wanted);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_temp = '0;
			duty_limit  = DUTY_RESET;
			phase       = 0;
			latest_temp = '0;
			wr_pos      = 0;
			fill        = 0;
			reached     = 1'b0;
			relay       = 1'b0;
			forecast_q.delete();
			words_due   = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_TARGET_TEMP) begin
					target_temp = $signed(cfg_data[TEMP_W-1:0]);
					reached = 1'b0;
				end else if (cfg_index == REG_DUTY_LIMIT) begin
					duty_limit = cfg_data[DUTY_W-1:0];
				end
			end
			if (result_valid && result_ready) begin
				if (forecast_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result word with none expected: on=%0b reached=%0b wanted=%0b",
							$realtime, result_data.heater_on, result_data.target_reached,
							result_data.heating_wanted);
				end else begin
					want = forecast_q.pop_front();
					if (result_data.heater_on !== want.heater_on
							|| result_data.target_reached !== want.target_reached
							|| result_data.heating_wanted !== want.heating_wanted)
						note_mismatch(want, result_data);
				end
			end
			if (item_valid && item_ready)
				forecast_q.push_back(step_controller(item_data));
			words_due = forecast_q.size();
		end
	end

endmodule

### sim/heater_duty_window_control_core_tb.sv
// Testbench top for heater_duty_window_control_core: clock, reset, stimulus and verdict.
// Depends on hdwc_pkg, hdwc_stream_if and the hdwc_result_check module.
module heater_duty_window_control_core_tb;
	import hdwc_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int RANDOM_ITEMS = 1800;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_CYCLES  = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int   fail_count;
	int   words_due;
	int   cycle_count = 0;
	int   items_sent;
	int   target_now;
	logic steady;
	logic want_hold;

	always #5 clk = ~clk;

	hdwc_stream_if #(.word_t(in_word_t))  item_ch ();
	hdwc_stream_if #(.word_t(out_word_t)) result_ch ();

	heater_duty_window_control_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hdwc_result_check result_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_ch.valid),
		.item_ready   (item_ch.ready),
		.item_data    (item_ch.data),
		.result_valid (result_ch.valid),
		.result_ready (result_ch.ready),
		.result_data  (result_ch.data),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.words_due    (words_due)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("heater_duty_window_control_core_tb NOT OK");
			$finish;
		end
	end

	function automatic in_word_t pack_word(logic kind, int temp, logic cov);
		in_word_t    w;
		logic [31:0] bits;
		bits = temp;
		w.kind          = kind;
		w.temperature   = bits[TEMP_W-1:0];
		w.level_covered = cov;
		return w;
	endfunction

	// offer one word, wait for acceptance, then maybe idle a while
	task automatic push_word(input in_word_t w);
		int gap;
		item_ch.valid <= 1'b1;
		item_ch.data  <= w;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		items_sent++;
		if (!steady && $urandom_range(0, 2) == 0) begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 2);
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic push_tick(input logic cov);
		push_word(pack_word(KIND_TICK, $urandom, cov));
	endtask

	task automatic push_sample(input int temp, input logic cov);
		push_word(pack_word(KIND_SAMPLE, temp, cov));
	endtask

	// write only with the pipe drained
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
		repeat (3) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_target(input int t);
		logic [31:0] bits;
		bits = t;
		target_now = t;
		write_reg(REG_TARGET_TEMP, bits[CFG_DATA_W-1:0]);
	endtask

	task automatic set_duty(input int d);
		logic [CFG_DATA_W-1:0] val;
		val = $urandom;
		val[DUTY_W-1:0] = d[DUTY_W-1:0];
		write_reg(REG_DUTY_LIMIT, val);
	endtask

	// result side: random ready, plus one long hold-off on request
	initial begin : result_side
		int   span;
		logic held;
		held = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (want_hold && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (steady || $urandom_range(0, 3) != 0) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end else begin
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
				result_ch.ready <= 1'b0;
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int   phase_no;
		int   phase_items;
		int   n;
		int   r;
		int   tv;
		logic cov;
		item_ch.valid   = 1'b0;
		item_ch.data    = '0;
		result_ch.ready = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		steady          = 1'b0;
		want_hold       = 1'b0;
		target_now      = 0;
		items_sent      = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: latest 0 is not below target 0, empty ring
		push_tick(1'b1);

		// hot target, zero duty: only phase 0 may heat
		set_target(2000);
		set_duty(0);
		push_sample(-880, 1'b0);
		push_tick(1'b1);
		push_tick(1'b1);
		push_tick(1'b0);
		push_sample(-2048, 1'b1);
		push_sample(2047, 1'b0);

		// coldest target; fill ring, one low reading blocks the flag
		set_target(-880);
		push_sample(-880, 1'b1);
		push_sample(0, 1'b0);
		push_tick(1'b1);
		push_sample(2000, 1'b1);
		push_sample(1000, 1'b0);
		push_sample(500, 1'b1);
		push_tick(1'b0);
		// flag is set now and must survive a cold sample
		push_sample(-2048, 1'b1);
		push_tick(1'b1);
		push_tick(1'b1);

		// duty out of range and near the top; target write clears the flag
		set_duty(127);
		set_target(100);
		push_tick(1'b1);
		push_tick(1'b1);
		set_duty(100);
		push_tick(1'b1);
		set_duty(99);
		push_tick(1'b1);

		items_sent = 0;
		phase_no = 0;
		while (items_sent < RANDOM_ITEMS) begin
			if (phase_no < 2 || $urandom_range(0, 3) != 0) begin
				r = $urandom_range(0, 9);
				case (r)
					0: set_target(-880);
					1: set_target(2000);
					2: set_target(-2048);
					3: set_target(2047);
					default: set_target($urandom_range(0, 2880) - 880);
				endcase
			end
			r = $urandom_range(0, 9);
			case (r)
				0: set_duty(0);
				1: set_duty(127);
				2: set_duty(99);
				3: set_duty(100);
				default: set_duty($urandom_range(0, 100));
			endcase
			steady <= (phase_no % 4 == 1);
			if (phase_no == 3)
				want_hold <= 1'b1;

			phase_items = 0;
			while (phase_items < PHASE_ITEMS && items_sent < RANDOM_ITEMS) begin
				// burst: a sample, then a run of ticks; some runs wrap the window
				if ($urandom_range(0, 19) != 0) begin
					r = $urandom_range(0, 19);
					if (r < 14)
						tv = target_now + $urandom_range(0, 60) - 20;
					else if (r < 17)
						tv = $urandom;
					else if (r == 17)
						tv = -2048;
					else if (r == 18)
						tv = 2047;
					else
						tv = ($urandom_range(0, 1) != 0) ? -880 : 2000;
					cov = ($urandom_range(0, 4) != 0);
					push_sample(tv, cov);
					phase_items++;
				end
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(95, 130) : $urandom_range(0, 25);
				repeat (n) begin
					cov = ($urandom_range(0, 4) != 0);
					push_tick(cov);
					phase_items++;
				end
			end
			phase_no++;
		end

		item_ch.valid <= 1'b0;
		do @(negedge clk); while (words_due != 0);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("heater_duty_window_control_core_tb OK");
		else
			$display("heater_duty_window_control_core_tb NOT OK");
		$finish;
	end

endmodule

### heater_duty_window_control_core.f
rtl/hdwc_pkg.sv
rtl/hdwc_stream_if.sv
rtl/heater_duty_window_control_core.sv
rtl/hdwc_checker.sv
sim/hdwc_result_check.sv
sim/heater_duty_window_control_core_tb.sv
